[src/evbd_pkg.sv]
// evbd_pkg: shared widths, register indexes, reset values, structs and states
// for the energy variance beat detector. No dependencies.
package evbd_pkg;

    localparam int MAG_W    = 16;
    localparam int SQ_W     = 32;
    localparam int ENERGY_W = 48;
    localparam int REG_W    = 24;
    localparam int MULT_W   = 32;
    localparam int VAR_W    = 64;
    localparam int REG_IDX_W = 1;

    localparam int FRAME_Q_DEPTH  = 4;
    localparam int RESULT_Q_DEPTH = 2;

    localparam logic [REG_IDX_W-1:0] REG_VARIANCE_SLOPE   = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_OFFSET = 1'd1;

    localparam logic [REG_W-1:0] SLOPE_RESET  = 24'd1685193;
    localparam logic [REG_W-1:0] OFFSET_RESET = 24'd99236;

    localparam logic [MULT_W-1:0] MULT_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [MULT_W-1:0] MULT_NEG_SAT = 32'h8000_0000;

    typedef struct packed {
        logic [REG_W-1:0] variance_slope;
        logic [REG_W-1:0] threshold_offset;
    } evbd_cfg_t;

    typedef struct packed {
        logic             start;
        logic [VAR_W-1:0] dividend;
    } evbd_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [VAR_W-1:0] quotient;
    } evbd_div_rsp_t;

    typedef struct packed {
        logic                     beat;
        logic [ENERGY_W-1:0]      frame_energy;
        logic [ENERGY_W-1:0]      history_mean;
        logic signed [MULT_W-1:0] multiplier;
    } evbd_result_t;

    localparam int RESULT_W = $bits(evbd_result_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN_DIV,
        ST_VAR,
        ST_VAR_DIV,
        ST_SLOPE,
        ST_MULT,
        ST_CMP_MUL,
        ST_CMP,
        ST_DONE
    } evbd_state_t;

endpackage

[src/evbd_ram.sv]
// evbd_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module evbd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 60
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/evbd_fifo.sv]
// evbd_fifo: small register-based show-ahead queue with occupancy count.
// No dependencies.
module evbd_fifo #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[src/evbd_front.sv]
// evbd_front: takes bin words, squares and accumulates frame energy, queues
// the finished frame energy. Depends on evbd_pkg.
module evbd_front import evbd_pkg::*; (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [MAG_W-1:0]                     magnitude,
    input  logic                                 last_bin,
    output logic                                 full,
    input  logic [$clog2(FRAME_Q_DEPTH+1)-1:0]   fq_count,
    output logic                                 fq_push,
    output logic [ENERGY_W-1:0]                  fq_energy
);

    localparam int QCW = $clog2(FRAME_Q_DEPTH + 1);

    logic                accept;
    logic [SQ_W-1:0]     sq_reg;
    logic                vld_s1_reg;
    logic                last_s1_reg;
    logic [ENERGY_W-1:0] acc_reg;
    logic [ENERGY_W:0]   acc_sum;
    logic [ENERGY_W-1:0] acc_next;

    // one slot kept free for a last bin still in the square stage
    assign full   = (fq_count >= QCW'(FRAME_Q_DEPTH - 1));
    assign accept = push && !full;

    assign acc_sum  = {1'b0, acc_reg} + (ENERGY_W + 1)'(sq_reg);
    assign acc_next = acc_sum[ENERGY_W] ? '1 : acc_sum[ENERGY_W-1:0];

    assign fq_push   = vld_s1_reg && last_s1_reg;
    assign fq_energy = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s1_reg  <= 1'b0;
            last_s1_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            vld_s1_reg  <= accept;
            last_s1_reg <= last_bin;
            if (vld_s1_reg)
            begin
                acc_reg <= last_s1_reg ? '0 : acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_reg <= SQ_W'(magnitude) * SQ_W'(magnitude);
        end
    end

endmodule

[src/evbd_div.sv]
// evbd_div: divider by a constant, one quotient byte per cycle by reciprocal
// multiplication of the partial remainder window. Depends on evbd_pkg.
module evbd_div import evbd_pkg::*; #(
    parameter int DIVISOR = 60
) (
    input  logic          clk,
    input  logic          rst_n,
    input  evbd_div_req_t req,
    output evbd_div_rsp_t rsp
);

    localparam int DIGIT_W = 8;
    localparam int DIGITS  = VAR_W / DIGIT_W;
    localparam int RW      = $clog2(DIVISOR);
    localparam int VW      = RW + DIGIT_W;
    localparam int SH      = VW + RW;
    localparam int MW      = VW + 1;
    localparam int PW      = VW + MW;
    localparam int CNT_W   = $clog2(DIGITS);
    // ceil(2^SH / DIVISOR): floor(window / DIVISOR) is exact for any window < 2^VW
    localparam logic [MW-1:0] RECIP = MW'((2 ** SH + DIVISOR - 1) / DIVISOR);

    logic [VAR_W-1:0]   dvd_reg;
    logic [VAR_W-1:0]   dvd_next;
    logic [RW-1:0]      rem_reg;
    logic [RW-1:0]      rem_next;
    logic [VW-1:0]      window;
    logic [PW-1:0]      prod;
    logic [DIGIT_W-1:0] q_digit;
    logic [VW-1:0]      q_times_d;
    logic [VW-1:0]      diff;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    assign window    = {rem_reg, dvd_reg[VAR_W-1 -: DIGIT_W]};
    assign prod      = PW'(window) * PW'(RECIP);
    assign q_digit   = prod[SH +: DIGIT_W];
    assign q_times_d = VW'(q_digit) * VW'(DIVISOR);
    assign diff      = window - q_times_d;
    assign rem_next  = diff[RW-1:0];
    assign dvd_next  = {dvd_reg[VAR_W-DIGIT_W-1:0], q_digit};

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

endmodule

[src/evbd_back.sv]
// evbd_back: per-frame sequencer: history mean and variance sweeps, threshold
// multiplier, beat compare, history update. Depends on evbd_pkg.
module evbd_back import evbd_pkg::*; #(
    parameter int HISTORY_DEPTH = 60
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  evbd_cfg_t                        cfg,
    input  logic                             fq_empty,
    input  logic [ENERGY_W-1:0]              fq_energy,
    output logic                             fq_pop,
    output logic                             ram_we,
    output logic [$clog2(HISTORY_DEPTH)-1:0] ram_waddr,
    output logic [ENERGY_W-1:0]              ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(HISTORY_DEPTH)-1:0] ram_raddr,
    input  logic [ENERGY_W-1:0]              ram_rdata,
    output evbd_div_req_t                    div_req,
    input  evbd_div_rsp_t                    div_rsp,
    input  logic                             res_full,
    output logic                             res_push,
    output evbd_result_t                     res_word
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int CW = $clog2(HISTORY_DEPTH + 4);
    localparam int SW = ENERGY_W + $clog2(HISTORY_DEPTH);
    localparam int PW = 80;

    evbd_state_t state_reg;
    evbd_state_t state_next;

    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic                issue;
    logic                rd_vld_reg;
    logic                live_reg;
    logic                d_vld_reg;
    logic                p_vld_reg;
    logic [FW-1:0]       fill_reg;
    logic [AW-1:0]       slot_reg;

    logic [ENERGY_W-1:0] energy_reg;
    logic [ENERGY_W-1:0] entry;
    logic [SW-1:0]       sum_reg;
    logic [ENERGY_W-1:0] mean_reg;
    logic [ENERGY_W-1:0] d_reg;
    logic [ENERGY_W-1:0] d_next;
    logic [31:0]         aa_reg;
    logic [47:0]         ab_reg;
    logic [63:0]         bb_reg;
    logic [VAR_W-1:0]    term;
    logic [VAR_W:0]      var_sum;
    logic [VAR_W-1:0]    var_acc_reg;
    logic [VAR_W-1:0]    var_acc_next;
    logic [VAR_W-1:0]    var_reg;
    logic [55:0]         slope_hi_reg;
    logic [55:0]         slope_lo_reg;
    logic [56:0]         slope_term;
    logic signed [59:0]  mult_wide;
    logic [MULT_W-1:0]   mult_next;
    logic [MULT_W-1:0]   mult_reg;
    logic [62:0]         pm_lo_reg;
    logic [46:0]         pm_hi_reg;
    logic [PW-1:0]       prod;
    logic [PW-1:0]       lhs;
    logic                mult_pos;
    logic                mean_nz;
    logic                beat_next;
    logic                beat_reg;

    // history read sweep
    assign issue     = (state_reg == ST_SUM || state_reg == ST_VAR)
                       && (cnt_reg < CW'(HISTORY_DEPTH));
    assign ram_re    = issue;
    assign ram_raddr = cnt_reg[AW-1:0];
    assign entry     = live_reg ? ram_rdata : '0;

    // variance term: floor(d^2 / 2^32) from three partial products
    assign d_next  = (entry >= mean_reg) ? entry - mean_reg : mean_reg - entry;
    assign term    = {aa_reg, 32'b0} + {15'b0, ab_reg, 1'b0} + {32'b0, bb_reg[63:32]};
    assign var_sum = {1'b0, var_acc_reg} + {1'b0, term};
    assign var_acc_next = var_sum[VAR_W] ? '1 : var_sum[VAR_W-1:0];

    // threshold multiplier
    assign slope_term = {1'b0, slope_hi_reg} + 57'(slope_lo_reg[55:32]);
    assign mult_wide  = $signed({36'b0, cfg.threshold_offset}) - $signed({3'b0, slope_term});

    always_comb
    begin
        if (mult_wide[59:31] == '0 || mult_wide[59:31] == '1)
        begin
            mult_next = mult_wide[31:0];
        end
        else
        begin
            mult_next = mult_wide[59] ? MULT_NEG_SAT : MULT_POS_SAT;
        end
    end

    // beat compare in units of 2^-48
    assign prod     = {17'b0, pm_lo_reg} + {1'b0, pm_hi_reg, 32'b0};
    assign lhs      = {16'b0, energy_reg, 16'b0};
    assign mult_pos = !mult_reg[MULT_W-1] && (mult_reg != '0);
    assign mean_nz  = (mean_reg != '0);

    always_comb
    begin
        priority if (mult_pos && mean_nz)
        begin
            beat_next = (lhs > prod);
        end
        else if (mult_reg[MULT_W-1] && mean_nz)
        begin
            beat_next = 1'b1;
        end
        else
        begin
            beat_next = (energy_reg != '0);
        end
    end

    assign cnt_next = (state_reg == ST_SUM || state_reg == ST_VAR) ? cnt_reg + 1'b1 : '0;

    assign ram_waddr = slot_reg;
    assign ram_wdata = energy_reg;

    assign res_word.beat         = beat_reg;
    assign res_word.frame_energy = energy_reg;
    assign res_word.history_mean = mean_reg;
    assign res_word.multiplier   = $signed(mult_reg);

    always_comb
    begin
        state_next       = state_reg;
        fq_pop           = 1'b0;
        res_push         = 1'b0;
        ram_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = VAR_W'(sum_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fq_empty)
                begin
                    fq_pop     = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (cnt_reg == CW'(HISTORY_DEPTH + 1))
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_MEAN_DIV;
                end
            end
            ST_MEAN_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_VAR;
                end
            end
            ST_VAR:
            begin
                div_req.dividend = var_acc_reg;
                if (cnt_reg == CW'(HISTORY_DEPTH + 3))
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_VAR_DIV;
                end
            end
            ST_VAR_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_SLOPE;
                end
            end
            ST_SLOPE:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                state_next = ST_CMP_MUL;
            end
            ST_CMP_MUL:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            live_reg   <= 1'b0;
            d_vld_reg  <= 1'b0;
            p_vld_reg  <= 1'b0;
            fill_reg   <= '0;
            slot_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= issue;
            live_reg   <= issue && (cnt_reg < CW'(fill_reg));
            d_vld_reg  <= rd_vld_reg && (state_reg == ST_VAR);
            p_vld_reg  <= d_vld_reg;
            if (ram_we)
            begin
                slot_reg <= (slot_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                if (fill_reg != FW'(HISTORY_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg  <= d_next;
        aa_reg <= 32'(d_reg[47:32]) * 32'(d_reg[47:32]);
        ab_reg <= 48'(d_reg[47:32]) * 48'(d_reg[31:0]);
        bb_reg <= 64'(d_reg[31:0]) * 64'(d_reg[31:0]);
        if (fq_pop)
        begin
            energy_reg  <= fq_energy;
            sum_reg     <= '0;
            var_acc_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_SUM && rd_vld_reg)
            begin
                sum_reg <= sum_reg + SW'(entry);
            end
            if (p_vld_reg)
            begin
                var_acc_reg <= var_acc_next;
            end
        end
        if (state_reg == ST_MEAN_DIV && div_rsp.done)
        begin
            mean_reg <= div_rsp.quotient[ENERGY_W-1:0];
        end
        if (state_reg == ST_VAR_DIV && div_rsp.done)
        begin
            var_reg <= div_rsp.quotient;
        end
        if (state_reg == ST_SLOPE)
        begin
            slope_hi_reg <= 56'(cfg.variance_slope) * 56'(var_reg[63:32]);
            slope_lo_reg <= 56'(cfg.variance_slope) * 56'(var_reg[31:0]);
        end
        if (state_reg == ST_MULT)
        begin
            mult_reg <= mult_next;
        end
        if (state_reg == ST_CMP_MUL)
        begin
            pm_lo_reg <= 63'(mult_reg[30:0]) * 63'(mean_reg[31:0]);
            pm_hi_reg <= 47'(mult_reg[30:0]) * 47'(mean_reg[47:32]);
        end
        if (state_reg == ST_CMP)
        begin
            beat_reg <= beat_next;
        end
    end

`ifndef SYNTHESIS
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_MEAN_DIV || state_reg == ST_VAR_DIV))
        else $error("divider result outside a divide state");

    a_pop_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        fq_pop |=> (state_reg == ST_SUM && cnt_reg == '0))
        else $error("frame word taken without starting the sum sweep");

    a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= FW'(HISTORY_DEPTH)) && (slot_reg <= AW'(HISTORY_DEPTH - 1)))
        else $error("history fill or slot out of range");

    a_fill_tracks_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && fill_reg != FW'(HISTORY_DEPTH)) |-> (FW'(slot_reg) == fill_reg))
        else $error("history write slot disagrees with fill count");
`endif

endmodule

[src/energy_variance_beat_detector.sv]
// Energy variance beat detector. Bin words enter through push/full at one per
// cycle: each magnitude is squared and added to a saturating Q16.32 frame energy,
// and the word with last_bin set closes the frame into a four-frame queue. Per
// frame, a sequencer sweeps the HISTORY_DEPTH-entry history RAM twice (mean, then
// variance) and runs two 8-step divisions by HISTORY_DEPTH (one quotient byte per
// step), then forms the Q16.16 multiplier and the beat compare, and waits if the
// result queue is full; that sequencer sets the frame rate. The bin input stalls
// only when the frame queue holds three frames. One result word per frame leaves
// through empty/pop.
// History entries not yet written read as zero; no clearing pass.
// Configuration writes take effect at once and belong to idle periods.
// Depends on evbd_pkg, evbd_front, evbd_fifo, evbd_ram, evbd_div, evbd_back.
module energy_variance_beat_detector import evbd_pkg::*; #(
    parameter int HISTORY_DEPTH = 60
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [MAG_W-1:0]         magnitude,
    input  logic                     last_bin,
    output logic                     empty,
    input  logic                     pop,
    output logic                     beat,
    output logic [ENERGY_W-1:0]      frame_energy,
    output logic [ENERGY_W-1:0]      history_mean,
    output logic signed [MULT_W-1:0] multiplier,
    input  logic                     cfg_write,
    input  logic [REG_IDX_W-1:0]     cfg_index,
    input  logic [REG_W-1:0]         cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    logic [REG_W-1:0] slope_reg;
    logic [REG_W-1:0] offset_reg;
    evbd_cfg_t        cfg;

    logic [$clog2(FRAME_Q_DEPTH+1)-1:0] fq_count;
    logic                fq_push;
    logic [ENERGY_W-1:0] fq_wdata;
    logic [ENERGY_W-1:0] fq_rdata;
    logic                fq_empty;
    logic                fq_pop;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENERGY_W-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [ENERGY_W-1:0] ram_rdata;

    evbd_div_req_t div_req;
    evbd_div_rsp_t div_rsp;

    logic          res_full;
    logic          res_push;
    evbd_result_t  res_word;
    logic [RESULT_W-1:0] res_rdata;
    evbd_result_t  res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg  <= SLOPE_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VARIANCE_SLOPE:   slope_reg  <= cfg_data;
                REG_THRESHOLD_OFFSET: offset_reg <= cfg_data;
            endcase
        end
    end

    assign cfg.variance_slope   = slope_reg;
    assign cfg.threshold_offset = offset_reg;

    evbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .magnitude (magnitude),
        .last_bin  (last_bin),
        .full      (full),
        .fq_count  (fq_count),
        .fq_push   (fq_push),
        .fq_energy (fq_wdata)
    );

    evbd_fifo #(
        .WIDTH (ENERGY_W),
        .DEPTH (FRAME_Q_DEPTH)
    ) u_frame_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (fq_wdata),
        .pop   (fq_pop),
        .rdata (fq_rdata),
        .empty (fq_empty),
        .full  (),
        .count (fq_count)
    );

    evbd_ram #(
        .WIDTH (ENERGY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    evbd_div #(
        .DIVISOR (HISTORY_DEPTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    evbd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fq_empty  (fq_empty),
        .fq_energy (fq_rdata),
        .fq_pop    (fq_pop),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_word  (res_word)
    );

    evbd_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (RESULT_Q_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_word),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty),
        .full  (res_full),
        .count ()
    );

    assign res_out      = evbd_result_t'(res_rdata);
    assign beat         = res_out.beat;
    assign frame_energy = res_out.frame_energy;
    assign history_mean = res_out.history_mean;
    assign multiplier   = res_out.multiplier;

endmodule

[verif/energy_variance_beat_detector_tb.sv]
// Self-checking bench for energy_variance_beat_detector: drives bin words, predicts the
// per-frame energy, history mean, multiplier and beat, and checks every result word.
// Depends on evbd_pkg and the energy_variance_beat_detector RTL.
module energy_variance_beat_detector_tb import evbd_pkg::*; ();

    localparam int HIST_DEPTH      = 60;
    localparam int SETTLE_CYCLES   = 2 * HIST_DEPTH + 200;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int PHASE_BINS      = 170;
    localparam int NUM_PHASES      = 6;

    typedef enum int {FRAME_WIDE, FRAME_QUIET, FRAME_STEADY, FRAME_SILENT} frame_style_t;

    class frame_scoreboard;
        logic [REG_W-1:0]    slope;
        logic [REG_W-1:0]    offset;
        logic [ENERGY_W-1:0] energy_acc;
        logic [ENERGY_W-1:0] history [HIST_DEPTH];
        int                  slot;
        evbd_result_t        pending [$];
        int                  errors;

        function new();
            slope      = SLOPE_RESET;
            offset     = OFFSET_RESET;
            energy_acc = '0;
            foreach (history[i])
                history[i] = '0;
            slot   = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
            if (idx == REG_VARIANCE_SLOPE)
                slope = value;
            else if (idx == REG_THRESHOLD_OFFSET)
                offset = value;
        endfunction

        function void note_bin(logic [MAG_W-1:0] mag, logic last);
            logic [SQ_W-1:0]       sq;
            logic [ENERGY_W:0]     total;
            logic [63:0]           hist_sum;
            logic [ENERGY_W-1:0]   mean;
            logic [ENERGY_W-1:0]   d;
            logic [127:0]          dw;
            logic [127:0]          var_sum;
            logic [VAR_W-1:0]      variance;
            logic [127:0]          prod;
            logic [127:0]          slope_term;
            logic signed [63:0]    ofs_s;
            logic signed [63:0]    st_s;
            logic signed [63:0]    mult_wide;
            logic signed [MULT_W-1:0] mult;
            logic signed [127:0]   lhs;
            logic signed [127:0]   rhs;
            evbd_result_t          r;

            sq = SQ_W'(mag) * SQ_W'(mag);
            total = {1'b0, energy_acc} + {17'd0, sq};
            energy_acc = total[ENERGY_W] ? '1 : total[ENERGY_W-1:0];
            if (!last)
                return;

            hist_sum = '0;
            foreach (history[i])
                hist_sum += 64'(history[i]);
            mean = ENERGY_W'(hist_sum / HIST_DEPTH);

            var_sum = '0;
            foreach (history[i])
            begin
                d = (history[i] >= mean) ? history[i] - mean : mean - history[i];
                dw = 128'(d);
                var_sum += (dw * dw) >> 32;
            end
            variance = (var_sum > 128'hFFFF_FFFF_FFFF_FFFF) ? '1 : var_sum[63:0];
            variance = variance / HIST_DEPTH;

            prod = 128'(slope) * 128'(variance);
            slope_term = prod >> 32;
            ofs_s = {40'd0, offset};
            st_s  = {8'd0, slope_term[55:0]};
            mult_wide = ofs_s - st_s;
            if (mult_wide < -64'sd2147483648)
                mult = MULT_NEG_SAT;
            else if (mult_wide > 64'sd2147483647)
                mult = MULT_POS_SAT;
            else
                mult = mult_wide[31:0];

            // exact compare in units of 2^-48
            lhs = {64'd0, energy_acc, 16'd0};
            rhs = mult * $signed({80'd0, mean});

            r.beat         = (lhs > rhs);
            r.frame_energy = energy_acc;
            r.history_mean = mean;
            r.multiplier   = mult;
            pending.insert(pending.size(), r);

            history[slot] = energy_acc;
            slot = (slot == HIST_DEPTH - 1) ? 0 : slot + 1;
            energy_acc = '0;
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch: %s got %0h expected %0h", what, got, want);
        endtask

        task check_word(logic b, logic [ENERGY_W-1:0] e, logic [ENERGY_W-1:0] m,
                        logic [MULT_W-1:0] mu);
            evbd_result_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result word with none expected", 64'(e), '0);
                return;
            end
            want = pending.pop_front();
            if (b !== want.beat)
                report_mismatch("beat", 64'(b), 64'(want.beat));
            if (e !== want.frame_energy)
                report_mismatch("frame_energy", 64'(e), 64'(want.frame_energy));
            if (m !== want.history_mean)
                report_mismatch("history_mean", 64'(m), 64'(want.history_mean));
            if (mu !== want.multiplier)
                report_mismatch("multiplier", 64'(mu), 64'(unsigned'(want.multiplier)));
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [MAG_W-1:0]         magnitude = '0;
    logic                     last_bin = 1'b0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic                     beat;
    logic [ENERGY_W-1:0]      frame_energy;
    logic [ENERGY_W-1:0]      history_mean;
    logic signed [MULT_W-1:0] multiplier;
    logic                     cfg_write = 1'b0;
    logic [REG_IDX_W-1:0]     cfg_index = '0;
    logic [REG_W-1:0]         cfg_data = '0;

    frame_scoreboard sb = new();
    int src_idle_odds  = 8;
    int sink_idle_odds = 4;
    int sink_stall     = 0;
    int cycle_count    = 0;

    energy_variance_beat_detector #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .magnitude    (magnitude),
        .last_bin     (last_bin),
        .empty        (empty),
        .pop          (pop),
        .beat         (beat),
        .frame_energy (frame_energy),
        .history_mean (history_mean),
        .multiplier   (multiplier),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_word(beat, frame_energy, history_mean, multiplier);
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (sink_stall > 0)
            begin
                pop <= 1'b0;
                sink_stall--;
            end
            else
            begin
                pop <= 1'b1;
                if (sink_idle_odds != 0 && $urandom_range(1, sink_idle_odds) == 1)
                    sink_stall = $urandom_range(1, 14);
            end
        end
    end

    task send_bin(input logic [MAG_W-1:0] mag, input logic last);
        int gap;
        if (src_idle_odds != 0 && $urandom_range(1, src_idle_odds) == 1)
        begin
            gap = $urandom_range(1, 14);
            repeat (gap)
            begin
                @(negedge clk);
                push <= 1'b0;
            end
        end
        @(negedge clk);
        push      <= 1'b1;
        magnitude <= mag;
        last_bin  <= last;
        do
            @(posedge clk);
        while (full);
        sb.note_bin(mag, last);
    endtask

    task wait_drained;
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task random_frames(input int budget);
        int              sent;
        int              len;
        int              pick;
        int              i;
        int              steady_len;
        frame_style_t    style;
        logic [MAG_W-1:0] steady_mag;
        logic [MAG_W-1:0] mag;
        steady_mag = MAG_W'($urandom_range(0, 65535));
        steady_len = $urandom_range(1, 6);
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                style = FRAME_WIDE;
            else if (pick < 60)
                style = FRAME_QUIET;
            else if (pick < 95)
                style = FRAME_STEADY;
            else
                style = FRAME_SILENT;
            pick = $urandom_range(0, 99);
            if (style == FRAME_STEADY)
                len = steady_len;
            else if (pick < 75)
                len = $urandom_range(1, 6);
            else if (pick < 95)
                len = $urandom_range(7, 30);
            else
                len = $urandom_range(31, 100);
            for (i = 0; i < len; i++)
            begin
                case (style)
                    FRAME_WIDE:   mag = MAG_W'($urandom_range(0, 65535));
                    FRAME_QUIET:  mag = MAG_W'($urandom_range(0, 1023));
                    FRAME_STEADY: mag = ($urandom_range(0, 15) == 0) ?
                                        MAG_W'($urandom_range(0, 65535)) : steady_mag;
                    default:      mag = '0;
                endcase
                send_bin(mag, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        int p;
        logic [REG_W-1:0] new_slope;
        logic [REG_W-1:0] new_offset;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty history, zero and full-scale frames
        send_bin(16'h0000, 1'b1);
        send_bin(16'hFFFF, 1'b1);
        send_bin(16'h0001, 1'b0);
        send_bin(16'h8000, 1'b0);
        send_bin(16'h5555, 1'b0);
        send_bin(16'hAAAA, 1'b0);
        send_bin(16'hFFFF, 1'b1);
        send_bin(16'h00FF, 1'b0);
        send_bin(16'hFF00, 1'b1);
        repeat (4)
        begin
            send_bin(16'h4000, 1'b0);
            send_bin(16'h4000, 1'b1);
        end
        send_bin(16'h1234, 1'b1);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    new_slope  = SLOPE_RESET;
                    new_offset = OFFSET_RESET;
                end
                1:
                begin
                    new_slope  = '0;
                    new_offset = '0;
                end
                2:
                begin
                    new_slope  = '1;
                    new_offset = '1;
                end
                3:
                begin
                    new_slope  = '0;
                    new_offset = '1;
                end
                4:
                begin
                    new_slope  = REG_W'($urandom_range(0, 65535));
                    new_offset = REG_W'($urandom_range(0, 24'hFFFFFF));
                end
                default:
                begin
                    new_slope  = REG_W'($urandom_range(0, 24'hFFFFFF));
                    new_offset = REG_W'($urandom_range(0, 24'hFFFFFF));
                end
            endcase
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_VARIANCE_SLOPE, new_slope);
                write_reg(REG_THRESHOLD_OFFSET, new_offset);
            end
            else
            begin
                write_reg(REG_THRESHOLD_OFFSET, new_offset);
                write_reg(REG_VARIANCE_SLOPE, new_slope);
            end
            if (p == NUM_PHASES - 1)
            begin
                src_idle_odds  = 0;
                sink_idle_odds = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: src_idle_odds = 2;
                    1: src_idle_odds = 6;
                    default: src_idle_odds = 20;
                endcase
                case ($urandom_range(0, 2))
                    0: sink_idle_odds = 2;
                    1: sink_idle_odds = 6;
                    default: sink_idle_odds = 20;
                endcase
            end
            random_frames(PHASE_BINS);
        end

        wait_drained();
        if (sb.pending.size() != 0)
            sb.report_mismatch("result words never delivered", 64'(sb.pending.size()), '0);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
